// File: rtl/core/assert_macros.svh
// Assertion macros used by the sha256d top level module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("implication failed");
`endif

// File: rtl/core/sha256d_pkg.sv
// Package for the sha256d midstate nonce hasher: round constants, IV, types.
// No dependencies.
package sha256d_pkg;
	localparam int unsigned Rounds = 64;
	localparam int unsigned NumRegs = 6;
	localparam int unsigned RegIdxW = 3;

	localparam logic [RegIdxW-1:0] REG_MID01 = 3'd0;
	localparam logic [RegIdxW-1:0] REG_MID23 = 3'd1;
	localparam logic [RegIdxW-1:0] REG_MID45 = 3'd2;
	localparam logic [RegIdxW-1:0] REG_MID67 = 3'd3;
	localparam logic [RegIdxW-1:0] REG_TAIL0 = 3'd4;
	localparam logic [RegIdxW-1:0] REG_TAIL1 = 3'd5;

	typedef logic [31:0] word_t;
	typedef word_t [7:0] state_t;
	typedef word_t [15:0] sched_t;

	localparam word_t [0:63] RK = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam state_t IV = '{
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	function automatic word_t rotr(word_t x, int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
endpackage

// File: rtl/core/sha256d_round_cell.sv
// One SHA-256 round cell: working state, a sliding 16-word schedule window,
// and the item's initial state, all registered. Uses sha256d_pkg.
module sha256d_round_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld_in,
	input  sha256d_pkg::word_t  k_in,
	input  sha256d_pkg::state_t st_in,
	input  sha256d_pkg::sched_t w_in,
	input  sha256d_pkg::state_t init_in,
	output logic                vld_out,
	output sha256d_pkg::state_t st_out,
	output sha256d_pkg::sched_t w_out,
	output sha256d_pkg::state_t init_out
);
	sha256d_pkg::word_t t1, t2, s0, s1, wn, a, e;
	sha256d_pkg::state_t st_nx;
	sha256d_pkg::sched_t w_nx;

	always_comb begin
		a = st_in[0];
		e = st_in[4];
		t1 = st_in[7] + (sha256d_pkg::rotr(e, 6) ^ sha256d_pkg::rotr(e, 11)
			^ sha256d_pkg::rotr(e, 25)) + ((e & st_in[5]) ^ (~e & st_in[6]))
			+ k_in + w_in[0];
		t2 = (sha256d_pkg::rotr(a, 2) ^ sha256d_pkg::rotr(a, 13)
			^ sha256d_pkg::rotr(a, 22))
			+ ((a & st_in[1]) ^ (a & st_in[2]) ^ (st_in[1] & st_in[2]));
		st_nx[7] = st_in[6];
		st_nx[6] = st_in[5];
		st_nx[5] = st_in[4];
		st_nx[4] = st_in[3] + t1;
		st_nx[3] = st_in[2];
		st_nx[2] = st_in[1];
		st_nx[1] = st_in[0];
		st_nx[0] = t1 + t2;
		s0 = sha256d_pkg::rotr(w_in[1], 7) ^ sha256d_pkg::rotr(w_in[1], 18)
			^ (w_in[1] >> 3);
		s1 = sha256d_pkg::rotr(w_in[14], 17) ^ sha256d_pkg::rotr(w_in[14], 19)
			^ (w_in[14] >> 10);
		wn = w_in[0] + s0 + w_in[9] + s1;
		for (int i = 0; i < 15; i++) begin
			w_nx[i] = w_in[i+1];
		end
		w_nx[15] = wn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		st_out   <= st_nx;
		w_out    <= w_nx;
		init_out <= init_in;
	end
endmodule

// File: rtl/core/sha256d_compress.sv
// Unrolled SHA-256 compression: a chain of 64 round cells and a registered
// final add of the initial state. Uses sha256d_pkg, sha256d_round_cell.
module sha256d_compress (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld_in,
	input  sha256d_pkg::state_t init_in,
	input  sha256d_pkg::sched_t blk_in,
	output logic                vld_out,
	output sha256d_pkg::state_t dig_out
);
	logic                vld_c  [0:sha256d_pkg::Rounds];
	sha256d_pkg::state_t st_c   [0:sha256d_pkg::Rounds];
	sha256d_pkg::sched_t w_c    [0:sha256d_pkg::Rounds];
	sha256d_pkg::state_t init_c [0:sha256d_pkg::Rounds];

	assign vld_c[0]  = vld_in;
	assign st_c[0]   = init_in;
	assign w_c[0]    = blk_in;
	assign init_c[0] = init_in;

	for (genvar r = 0; r < sha256d_pkg::Rounds; r++) begin : g_rnd
		sha256d_round_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.vld_in(vld_c[r]), .k_in(sha256d_pkg::RK[r]),
			.st_in(st_c[r]), .w_in(w_c[r]), .init_in(init_c[r]),
			.vld_out(vld_c[r+1]), .st_out(st_c[r+1]),
			.w_out(w_c[r+1]), .init_out(init_c[r+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_c[sha256d_pkg::Rounds];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 8; i++) begin
			dig_out[i] <= st_c[sha256d_pkg::Rounds][i] + init_c[sha256d_pkg::Rounds][i];
		end
	end
endmodule

// File: rtl/core/nonce_double_sha256_midstate.sv
// Top level of the double SHA-256 nonce hasher with a configured midstate.
// Uses sha256d_pkg, sha256d_compress, assert_macros.svh.
//
// Usage: write the midstate (registers 0..3) and header bytes 64..75
// (registers 4, 5) through cfg_valid/cfg_ready/cfg_index/cfg_data while idle.
// cfg_ready is always high; writes to unknown indexes are dropped.
// An item (nonce) is taken on each edge where start is high and busy low.
// busy is never high, so one nonce per cycle is accepted.
// From start to done: an input register, 64 round cells
// plus a final add for each of the two compressions, and an output register.
// Throughput is one item per cycle; both compressions are fully unrolled
// chains of round cells, each cell one SHA-256 round.
// done is high for one cycle with the four 64-bit hash outputs; the receiver cannot
// stall, results are simply presented in order.
// Reset clears all valid flags and the configuration registers to zero;
// items in flight are dropped.
`include "assert_macros.svh"
module nonce_double_sha256_midstate (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] nonce,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [sha256d_pkg::RegIdxW-1:0] cfg_index,
	input  logic [63:0] cfg_data,
	output logic        done,
	output logic [63:0] hash_bytes_0_7,
	output logic [63:0] hash_bytes_8_15,
	output logic [63:0] hash_bytes_16_23,
	output logic [63:0] hash_bytes_24_31
);
	logic [63:0] mid01_q, mid23_q, mid45_q, mid67_q, tail0_q;
	logic [31:0] tail1_q;
	logic        vld_s1;
	sha256d_pkg::state_t mid_s1;
	sha256d_pkg::sched_t blk1, blk_s1, blk2;
	logic                vld_a, vld_b;
	sha256d_pkg::state_t dig_a, dig_b;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid01_q <= '0;
			mid23_q <= '0;
			mid45_q <= '0;
			mid67_q <= '0;
			tail0_q <= '0;
			tail1_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sha256d_pkg::REG_MID01: mid01_q <= cfg_data;
				sha256d_pkg::REG_MID23: mid23_q <= cfg_data;
				sha256d_pkg::REG_MID45: mid45_q <= cfg_data;
				sha256d_pkg::REG_MID67: mid67_q <= cfg_data;
				sha256d_pkg::REG_TAIL0: tail0_q <= cfg_data;
				sha256d_pkg::REG_TAIL1: tail1_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_comb begin
		blk1 = '0;
		blk1[0] = tail0_q[63:32];
		blk1[1] = tail0_q[31:0];
		blk1[2] = tail1_q;
		blk1[3] = {nonce[7:0], nonce[15:8], nonce[23:16], nonce[31:24]};
		blk1[4] = 32'h80000000;
		blk1[15] = 32'd640;
	end

	always_ff @(posedge clk) begin
		mid_s1 <= '{mid67_q[31:0], mid67_q[63:32], mid45_q[31:0], mid45_q[63:32],
			mid23_q[31:0], mid23_q[63:32], mid01_q[31:0], mid01_q[63:32]};
		blk_s1 <= blk1;
	end

	sha256d_compress u_first (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_s1), .init_in(mid_s1),
		.blk_in(blk_s1), .vld_out(vld_a), .dig_out(dig_a)
	);

	always_comb begin
		blk2 = '0;
		for (int i = 0; i < 8; i++) begin
			blk2[i] = dig_a[i];
		end
		blk2[8] = 32'h80000000;
		blk2[15] = 32'd256;
	end

	sha256d_compress u_second (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_a), .init_in(sha256d_pkg::IV),
		.blk_in(blk2), .vld_out(vld_b), .dig_out(dig_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_b;
		end
	end

	always_ff @(posedge clk) begin
		hash_bytes_0_7   <= {dig_b[0], dig_b[1]};
		hash_bytes_8_15  <= {dig_b[2], dig_b[3]};
		hash_bytes_16_23 <= {dig_b[4], dig_b[5]};
		hash_bytes_24_31 <= {dig_b[6], dig_b[7]};
	end

	`ASSERT_CLK(a_busy_low, clk, arst_n, !busy)
	`ASSERT_IMPL(a_first_to_second, clk, arst_n, vld_a, ##66 done)
	`ASSERT_IMPL(a_start_to_first, clk, arst_n, start && !busy, ##66 vld_a)
endmodule
